// ===== hw/rtl/obo_pkg.sv =====
// Shared widths and edge-pair tables for the oriented box overlap test.
package obo_pkg;

    localparam int COORD_BITS = 24;                // signed Q15.8 at the default width
    localparam int DIFF_BITS  = COORD_BITS + 1;    // center difference
    localparam int PROD_BITS  = 2 * COORD_BITS;    // edge x edge product
    localparam int DOT_BITS   = PROD_BITS + 1;     // signed edge dot product
    localparam int CPROD_BITS = 2 * COORD_BITS + 1; // center x edge product
    localparam int CDOT_BITS  = CPROD_BITS + 1;    // signed center dot product
    localparam int CMAG_BITS  = CPROD_BITS;        // |center dot|
    localparam int SUM_BITS   = PROD_BITS + 2;     // extent sum and doubled distance

    localparam int NUM_EDGES = 4;
    localparam int NUM_PAIRS = 10;

    // Unordered edge pairs (a <= b); edges: left x, left y, right x, right y
    localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int PAIR_B [NUM_PAIRS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

    // Pair index of edges (i, j), symmetric
    localparam int PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
        '{0, 1, 2, 3},
        '{1, 4, 5, 6},
        '{2, 5, 7, 8},
        '{3, 6, 8, 9}
    };

endpackage

// ===== hw/rtl/obo_if.sv =====
// Box pair and result channel interfaces.
interface obo_pair_if;
    import obo_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] left_xedge_x;
    logic signed [COORD_BITS-1:0] left_xedge_y;
    logic signed [COORD_BITS-1:0] left_yedge_x;
    logic signed [COORD_BITS-1:0] left_yedge_y;
    logic signed [COORD_BITS-1:0] left_center_x;
    logic signed [COORD_BITS-1:0] left_center_y;
    logic signed [COORD_BITS-1:0] right_xedge_x;
    logic signed [COORD_BITS-1:0] right_xedge_y;
    logic signed [COORD_BITS-1:0] right_yedge_x;
    logic signed [COORD_BITS-1:0] right_yedge_y;
    logic signed [COORD_BITS-1:0] right_center_x;
    logic signed [COORD_BITS-1:0] right_center_y;

    modport source (
        output valid,
        output left_xedge_x, left_xedge_y, left_yedge_x, left_yedge_y,
        output left_center_x, left_center_y,
        output right_xedge_x, right_xedge_y, right_yedge_x, right_yedge_y,
        output right_center_x, right_center_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_xedge_x, left_xedge_y, left_yedge_x, left_yedge_y,
        input  left_center_x, left_center_y,
        input  right_xedge_x, right_xedge_y, right_yedge_x, right_yedge_y,
        input  right_center_x, right_center_y,
        output ready
    );
endinterface

interface obo_result_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid,
        output overlap,
        input  ready
    );

    modport sink (
        input  valid,
        input  overlap,
        output ready
    );
endinterface

// ===== hw/rtl/oriented_box_overlap_test.sv =====
// Pipelined 2D oriented box separating axis test.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------
//  pair     | in  | two boxes: x edge, y edge, center (12 x COORD_BITS)
//  result   | out | overlap (1 bit)
//
// One box pair per cycle while the result side keeps accepting; five register
// stages (input/diff, multiply, dot+abs, extent sum, compare) lie between a
// pair's transfer and its result being offered.
// Reset clears the stage valid bits only.
// Each stage holds while the one after it is full and stalled, so bubbles
// collapse and pairs keep being taken while a result waits.
module oriented_box_overlap_test (
    input  logic          clk,
    input  logic          rst_n,
    obo_pair_if.sink      pair,
    obo_result_if.source  result
);
    import obo_pkg::*;

    // Stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // Stage 1: edges and center difference
    logic signed [COORD_BITS-1:0] ex_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] ey_reg [NUM_EDGES];
    logic signed [DIFF_BITS-1:0]  cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] ex_next [NUM_EDGES];
    logic signed [COORD_BITS-1:0] ey_next [NUM_EDGES];
    logic signed [DIFF_BITS-1:0]  cx_next, cy_next;

    // Stage 2: products
    logic signed [PROD_BITS-1:0]  px_reg [NUM_PAIRS];
    logic signed [PROD_BITS-1:0]  py_reg [NUM_PAIRS];
    logic signed [CPROD_BITS-1:0] cpx_reg [NUM_EDGES];
    logic signed [CPROD_BITS-1:0] cpy_reg [NUM_EDGES];
    logic signed [PROD_BITS-1:0]  px_next [NUM_PAIRS];
    logic signed [PROD_BITS-1:0]  py_next [NUM_PAIRS];
    logic signed [CPROD_BITS-1:0] cpx_next [NUM_EDGES];
    logic signed [CPROD_BITS-1:0] cpy_next [NUM_EDGES];

    // Stage 3: absolute dot products
    logic signed [DOT_BITS-1:0]  dot_sum [NUM_PAIRS];
    logic signed [CDOT_BITS-1:0] cdot_sum [NUM_EDGES];
    logic [PROD_BITS-1:0] dot_mag_reg [NUM_PAIRS];
    logic [CMAG_BITS-1:0] dist_reg [NUM_EDGES];
    logic [PROD_BITS-1:0] dot_mag_next [NUM_PAIRS];
    logic [CMAG_BITS-1:0] dist_next [NUM_EDGES];

    // Stage 4: extents and doubled distances per axis
    logic [SUM_BITS-1:0] extent_reg [NUM_EDGES];
    logic [SUM_BITS-1:0] dist2_reg [NUM_EDGES];
    logic [SUM_BITS-1:0] extent_next [NUM_EDGES];
    logic [SUM_BITS-1:0] dist2_next [NUM_EDGES];

    // Stage 5: result register
    logic overlap_reg;
    logic overlap_next;
    logic separated;

    assign en5 = !v5_reg || result.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pair.ready     = en1;
    assign result.valid   = v5_reg;
    assign result.overlap = overlap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pair.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1
    always_comb
    begin
        ex_next[0] = pair.left_xedge_x;
        ey_next[0] = pair.left_xedge_y;
        ex_next[1] = pair.left_yedge_x;
        ey_next[1] = pair.left_yedge_y;
        ex_next[2] = pair.right_xedge_x;
        ey_next[2] = pair.right_xedge_y;
        ex_next[3] = pair.right_yedge_x;
        ey_next[3] = pair.right_yedge_y;
        cx_next = DIFF_BITS'(pair.left_center_x) - DIFF_BITS'(pair.right_center_x);
        cy_next = DIFF_BITS'(pair.left_center_y) - DIFF_BITS'(pair.right_center_y);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    // Stage 2: edge pair products and center products
    always_comb
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            px_next[p] = PROD_BITS'(ex_reg[PAIR_A[p]]) * PROD_BITS'(ex_reg[PAIR_B[p]]);
            py_next[p] = PROD_BITS'(ey_reg[PAIR_A[p]]) * PROD_BITS'(ey_reg[PAIR_B[p]]);
        end
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            cpx_next[i] = CPROD_BITS'(cx_reg) * CPROD_BITS'(ex_reg[i]);
            cpy_next[i] = CPROD_BITS'(cy_reg) * CPROD_BITS'(ey_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            cpx_reg <= cpx_next;
            cpy_reg <= cpy_next;
        end
    end

    // Stage 3: dot sums and magnitudes
    always_comb
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            dot_sum[p] = DOT_BITS'(px_reg[p]) + DOT_BITS'(py_reg[p]);
            dot_mag_next[p] = dot_sum[p][DOT_BITS-1] ? PROD_BITS'(-dot_sum[p])
                                                     : PROD_BITS'(dot_sum[p]);
        end
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            cdot_sum[i] = CDOT_BITS'(cpx_reg[i]) + CDOT_BITS'(cpy_reg[i]);
            dist_next[i] = cdot_sum[i][CDOT_BITS-1] ? CMAG_BITS'(-cdot_sum[i])
                                                    : CMAG_BITS'(cdot_sum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            dot_mag_reg <= dot_mag_next;
            dist_reg    <= dist_next;
        end
    end

    // Stage 4: projected extent of both boxes on each axis
    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            extent_next[i] = '0;
            for (int j = 0; j < NUM_EDGES; j++)
            begin
                extent_next[i] = extent_next[i] + SUM_BITS'(dot_mag_reg[PAIR_OF[i][j]]);
            end
            dist2_next[i] = {dist_reg[i], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            extent_reg <= extent_next;
            dist2_reg  <= dist2_next;
        end
    end

    // Stage 5: strict separation on any axis clears overlap
    always_comb
    begin
        separated = 1'b0;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            separated = separated | (extent_reg[i] < dist2_reg[i]);
        end
        overlap_next = !separated;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            overlap_reg <= overlap_next;
        end
    end

    // A transfer always lands in the first stage
    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready) |=> v1_reg)
        else $error("accepted pair missing from stage 1");

    // A full, stalled pipeline takes nothing new
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !result.ready) |-> !pair.ready)
        else $error("pair taken while pipeline full");

    // An empty pipeline is always ready
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg) |-> pair.ready)
        else $error("empty pipeline not ready");

    // A held stage keeps its item
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !en4) |=> v4_reg)
        else $error("stalled stage 4 item lost");

endmodule

// ===== verif/tb_oriented_box_overlap_test.sv =====
// Self-checking testbench for the oriented box overlap test: directed and random box pairs.
module tb_oriented_box_overlap_test;
    import obo_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left_xedge_x;
        coord_t left_xedge_y;
        coord_t left_yedge_x;
        coord_t left_yedge_y;
        coord_t left_center_x;
        coord_t left_center_y;
        coord_t right_xedge_x;
        coord_t right_xedge_y;
        coord_t right_yedge_x;
        coord_t right_yedge_y;
        coord_t right_center_x;
        coord_t right_center_y;
    } box_pair_t;

    localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam int NUM_RANDOM  = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    obo_pair_if   pair_ch ();
    obo_result_if result_ch ();

    oriented_box_overlap_test uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (result_ch)
    );

    box_pair_t pending_pairs [$];
    logic      overlap_expected [$];
    box_pair_t offered;
    logic      want;
    int        total_pairs;
    int        pairs_accepted;
    int        results_seen;
    int        errors;
    int        cycles;
    int        send_gap;
    int        recv_stall;
    logic      hold_off;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("oriented_box_overlap_test: mismatch");
            $finish;
        end
    end

    // |a.b| held exactly; 128 bits leaves plenty of headroom
    function automatic logic signed [127:0] proj_mag(logic signed [63:0] ax,
                                                      logic signed [63:0] ay,
                                                      logic signed [63:0] bx,
                                                      logic signed [63:0] by);
        logic signed [127:0] s;
        s = ax * bx + ay * by;
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic predict_overlap(box_pair_t p);
        logic signed [63:0]  ex [4];
        logic signed [63:0]  ey [4];
        logic signed [63:0]  cx;
        logic signed [63:0]  cy;
        logic signed [127:0] extent;
        logic signed [127:0] cdist;
        logic                hit;
        ex[0] = $signed(p.left_xedge_x);   ey[0] = $signed(p.left_xedge_y);
        ex[1] = $signed(p.left_yedge_x);   ey[1] = $signed(p.left_yedge_y);
        ex[2] = $signed(p.right_xedge_x);  ey[2] = $signed(p.right_xedge_y);
        ex[3] = $signed(p.right_yedge_x);  ey[3] = $signed(p.right_yedge_y);
        cx = $signed(p.left_center_x);
        cx = cx - $signed(p.right_center_x);
        cy = $signed(p.left_center_y);
        cy = cy - $signed(p.right_center_y);
        hit = 1'b1;
        for (int i = 0; i < NUM_EDGES; i++) begin
            extent = 0;
            for (int j = 0; j < NUM_EDGES; j++)
                extent = extent + proj_mag(ex[j], ey[j], ex[i], ey[i]);
            cdist = 2 * proj_mag(cx, cy, ex[i], ey[i]);
            // strict: touching is still overlap, zero axis never separates
            if (extent < cdist)
                hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic box_pair_t box_pair(coord_t lxx, coord_t lxy, coord_t lyx, coord_t lyy,
                                           coord_t lcx, coord_t lcy,
                                           coord_t rxx, coord_t rxy, coord_t ryx, coord_t ryy,
                                           coord_t rcx, coord_t rcy);
        box_pair_t p;
        p.left_xedge_x  = lxx;  p.left_xedge_y  = lxy;
        p.left_yedge_x  = lyx;  p.left_yedge_y  = lyy;
        p.left_center_x = lcx;  p.left_center_y = lcy;
        p.right_xedge_x = rxx;  p.right_xedge_y = rxy;
        p.right_yedge_x = ryx;  p.right_yedge_y = ryy;
        p.right_center_x = rcx; p.right_center_y = rcy;
        return p;
    endfunction

    // signed value spanning w bits
    function automatic coord_t rand_coord(int w);
        logic [31:0] r;
        r = $urandom;
        return $signed(r[COORD_BITS-1:0]) >>> (COORD_BITS - w);
    endfunction

    // mostly no gap, some short, few long; gap-free stretches every so often
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycles[10:9] == 2'd0) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR: result %0d: %s", results_seen, what);
        errors++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pair_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else begin
            if (pair_ch.valid && pair_ch.ready) begin
                overlap_expected.push_back(predict_overlap(offered));
                pairs_accepted++;
            end
            if (!pair_ch.valid || pair_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    pair_ch.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0) begin
                    offered = pending_pairs.pop_front();
                    pair_ch.left_xedge_x   <= offered.left_xedge_x;
                    pair_ch.left_xedge_y   <= offered.left_xedge_y;
                    pair_ch.left_yedge_x   <= offered.left_yedge_x;
                    pair_ch.left_yedge_y   <= offered.left_yedge_y;
                    pair_ch.left_center_x  <= offered.left_center_x;
                    pair_ch.left_center_y  <= offered.left_center_y;
                    pair_ch.right_xedge_x  <= offered.right_xedge_x;
                    pair_ch.right_xedge_y  <= offered.right_xedge_y;
                    pair_ch.right_yedge_x  <= offered.right_yedge_x;
                    pair_ch.right_yedge_y  <= offered.right_yedge_y;
                    pair_ch.right_center_x <= offered.right_center_x;
                    pair_ch.right_center_y <= offered.right_center_y;
                    pair_ch.valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else begin
                    pair_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            recv_stall <= 0;
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                if (overlap_expected.size() == 0) begin
                    report_mismatch($sformatf("overlap=%0b with nothing outstanding",
                                              result_ch.overlap));
                end
                else begin
                    want = overlap_expected.pop_front();
                    if (result_ch.overlap !== want)
                        report_mismatch($sformatf("overlap=%0b, predicted %0b",
                                                  result_ch.overlap, want));
                end
                results_seen++;
            end
            if (hold_off) begin
                result_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // long receiver hold-off so the pipeline fills and backpressures the sender
    initial begin
        hold_off = 1'b0;
        while (pairs_accepted < 100)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        coord_t    f [12];
        coord_t    a;
        coord_t    b;
        coord_t    c;
        coord_t    d;
        coord_t    h;
        coord_t    lc;
        int        kind;
        int        w;
        box_pair_t p;

        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        pairs_accepted = 0;
        results_seen = 0;
        pair_ch.valid = 1'b0;
        pair_ch.left_xedge_x = '0;   pair_ch.left_xedge_y = '0;
        pair_ch.left_yedge_x = '0;   pair_ch.left_yedge_y = '0;
        pair_ch.left_center_x = '0;  pair_ch.left_center_y = '0;
        pair_ch.right_xedge_x = '0;  pair_ch.right_xedge_y = '0;
        pair_ch.right_yedge_x = '0;  pair_ch.right_yedge_y = '0;
        pair_ch.right_center_x = '0; pair_ch.right_center_y = '0;
        result_ch.ready = 1'b0;

        // directed: extremes, degenerate boxes, touching and just apart
        pending_pairs.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(box_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                         CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        pending_pairs.push_back(box_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                         CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        pending_pairs.push_back(box_pair(CMAX, 0, 0, CMAX, CMAX, CMAX,
                                         CMAX, 0, 0, CMAX, CMIN, CMIN));
        pending_pairs.push_back(box_pair(CMIN, 0, 0, CMIN, CMIN, CMAX,
                                         CMIN, 0, 0, CMIN, CMAX, CMIN));
        pending_pairs.push_back(box_pair(256, 0, 0, 256, 0, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(512, 0, 0, 256, 384, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(512, 0, 0, 256, 385, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(512, 0, 0, 256, -384, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(-512, 0, 0, -256, 384, 0, -256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(0, 512, 256, 0, 0, 384, 0, 256, 256, 0, 0, 0));
        pending_pairs.push_back(box_pair(0, 512, 256, 0, 0, -385, 0, 256, 256, 0, 0, 0));
        pending_pairs.push_back(box_pair(256, 256, -256, 256, 0, 0,
                                         256, 0, 0, 256, 600, 0));
        pending_pairs.push_back(box_pair(256, 256, -256, 256, 0, 0,
                                         256, 0, 0, 256, 1200, 0));
        pending_pairs.push_back(box_pair(0, 0, 0, 0, CMAX, CMAX, 0, 0, 0, 0, CMIN, CMIN));
        pending_pairs.push_back(box_pair(0, 0, 0, 0, 5000, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(0, 0, 0, 0, 100, 0, 256, 0, 0, 256, 0, 0));
        pending_pairs.push_back(box_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN,
                                         CMIN, CMAX, CMAX, CMIN, CMIN, CMAX));
        pending_pairs.push_back(box_pair(1, -1, -1, 1, 1, -1, -1, 1, 1, -1, -1, 1));
        pending_pairs.push_back(box_pair(1, 0, 0, 1, 1, 0, 1, 0, 0, 1, 0, 0));
        pending_pairs.push_back(box_pair(1, 0, 0, 1, 2, 0, 1, 0, 0, 1, 0, 0));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // nearby boxes of similar scale, either outcome likely
                w = $urandom_range(1, 16);
                for (int k = 0; k < 12; k++)
                    f[k] = rand_coord(w);
                f[4]  = rand_coord(22);
                f[5]  = rand_coord(22);
                f[10] = f[4] + rand_coord(w + 1);
                f[11] = f[5] + rand_coord(w + 1);
            end
            else if (kind < 55) begin
                // axis-aligned pair on the edge of contact, one LSB either way
                a = $urandom_range(1, 4095);
                c = $urandom_range(1, 4095);
                if ((a + c) % 2 != 0)
                    c = c + 1;
                b = $urandom_range(1, 4095);
                d = $urandom_range(1, 4095);
                h = (a + c) / 2 + $signed($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    h = -h;
                lc = rand_coord(20);
                if ($urandom_range(0, 1)) a = -a;
                if ($urandom_range(0, 1)) d = -d;
                if ($urandom_range(0, 1)) begin
                    f = '{a, 0, 0, b, lc, 0, c, 0, 0, d, lc - h, 0};
                end
                else begin
                    f = '{0, a, b, 0, 0, lc, 0, c, d, 0, 0, lc - h};
                end
            end
            else if (kind < 80) begin
                for (int k = 0; k < 12; k++)
                    f[k] = rand_coord($urandom_range(1, COORD_BITS));
            end
            else if (kind < 90) begin
                for (int k = 0; k < 12; k++) begin
                    case ($urandom_range(0, 4))
                        0: f[k] = CMAX;
                        1: f[k] = CMIN;
                        2: f[k] = 0;
                        3: f[k] = 1;
                        default: f[k] = -1;
                    endcase
                end
            end
            else begin
                for (int k = 0; k < 12; k++)
                    f[k] = rand_coord(COORD_BITS);
            end
            p = box_pair(f[0], f[1], f[2], f[3], f[4], f[5],
                         f[6], f[7], f[8], f[9], f[10], f[11]);
            pending_pairs.push_back(p);
        end
        total_pairs = pending_pairs.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pairs_accepted < total_pairs)
            @(posedge clk);
        while (overlap_expected.size() != 0)
            @(posedge clk);
        // pipeline is 5 deep; anything extra would show up by now
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("oriented_box_overlap_test: match");
        else
            $display("oriented_box_overlap_test: mismatch");
        $finish;
    end

endmodule
